// ----- sv/keyword_token_lexer_top_macros.svh -----
// ----------------------------------------------------------------------------
// keyword_token_lexer_top_macros.svh
// Assertion macros shared by the lexer checker.
// ----------------------------------------------------------------------------
`ifndef KEYWORD_TOKEN_LEXER_TOP_MACROS_SVH
`define KEYWORD_TOKEN_LEXER_TOP_MACROS_SVH

// Clocked assertion, off while reset is asserted.
`define KWL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define KWL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- sv/kwl_pkg.sv -----
// ----------------------------------------------------------------------------
// kwl_pkg
// Types, character codes and keyword table of the keyword token lexer.
// ----------------------------------------------------------------------------
`default_nettype none

package kwl_pkg;

  localparam int POS_BITS = 16;
  localparam int LEN_BITS = 8;
  localparam int KW_BYTES = 5;
  localparam int KW_COUNT = 8;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_NUM   = 2'd1,
    MODE_IDENT = 2'd2,
    MODE_EQ    = 2'd3
  } mode_e;

  typedef enum logic [4:0] {
    KIND_EOF     = 5'd0,
    KIND_PLUS    = 5'd1,
    KIND_MINUS   = 5'd2,
    KIND_STAR    = 5'd3,
    KIND_SLASH   = 5'd4,
    KIND_EQUAL   = 5'd5,
    KIND_EQEQ    = 5'd6,
    KIND_LESS    = 5'd7,
    KIND_LPAREN  = 5'd8,
    KIND_RPAREN  = 5'd9,
    KIND_LBRACE  = 5'd10,
    KIND_RBRACE  = 5'd11,
    KIND_NUMBER  = 5'd12,
    KIND_IDENT   = 5'd13,
    KIND_LET     = 5'd14,
    KIND_PRINT   = 5'd15,
    KIND_IF      = 5'd16,
    KIND_ELSE    = 5'd17,
    KIND_WHILE   = 5'd18,
    KIND_TRUE    = 5'd19,
    KIND_FALSE   = 5'd20,
    KIND_INPUT   = 5'd21
  } kind_e;

  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LESS   = 8'h3C;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_EQ     = 8'h3D;

  typedef logic [KW_BYTES-1:0][7:0] prefix_t;

  // First byte of each keyword sits in the low byte.
  localparam prefix_t KW_TEXT [KW_COUNT] = '{
    40'h000074656C,   // let
    40'h746E697270,   // print
    40'h0000006669,   // if
    40'h0065736C65,   // else
    40'h656C696877,   // while
    40'h0065757274,   // true
    40'h65736C6166,   // false
    40'h7475706E69    // input
  };
  localparam logic [2:0] KW_LEN [KW_COUNT] = '{
    3'd3, 3'd5, 3'd2, 3'd4, 3'd5, 3'd4, 3'd5, 3'd5
  };

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_source;
  } in_t;

  typedef struct packed {
    kind_e               token_kind;
    logic [POS_BITS-1:0] start_pos;
    logic [LEN_BITS-1:0] token_len;
    logic                len_saturated;
    logic                last_of_run;
  } out_t;

  // Up to two tokens per item, in order: a then b.
  typedef struct packed {
    logic a_vld;
    out_t a;
    logic b_vld;
    out_t b;
  } kwl_push_t;

  function automatic kind_e op_kind(input logic [7:0] c);
    kind_e k;
    case (c)
      CH_PLUS:   k = KIND_PLUS;
      CH_MINUS:  k = KIND_MINUS;
      CH_STAR:   k = KIND_STAR;
      CH_SLASH:  k = KIND_SLASH;
      CH_LESS:   k = KIND_LESS;
      CH_LPAREN: k = KIND_LPAREN;
      CH_RPAREN: k = KIND_RPAREN;
      CH_LBRACE: k = KIND_LBRACE;
      CH_RBRACE: k = KIND_RBRACE;
      default:   k = KIND_EOF;
    endcase
    return k;
  endfunction

  function automatic kind_e ident_kind(input prefix_t pfx, input logic [LEN_BITS-1:0] len,
                                       input logic ovf);
    kind_e k;
    k = KIND_IDENT;
    if (!ovf && len <= LEN_BITS'(KW_BYTES)) begin
      for (int i = 0; i < KW_COUNT; i++) begin
        if (len == LEN_BITS'(KW_LEN[i]) && pfx == KW_TEXT[i]) begin
          k = kind_e'(5'(KIND_LET) + 5'(i));
        end
      end
    end
    return k;
  endfunction

endpackage

`default_nettype wire

// ----- sv/kwl_scan.sv -----
// ----------------------------------------------------------------------------
// kwl_scan
// Input register, state and tokens; one byte per cycle while room_i is set.
// ----------------------------------------------------------------------------
`default_nettype none

module kwl_scan import kwl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_t       in_i,
  input  logic      room_i,
  output kwl_push_t push_o
);

  localparam logic [POS_BITS-1:0] POS_MAX = '1;
  localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

  logic                in_vld_q;
  in_t                 in_q;
  mode_e               mode_q, mode_d;
  logic [POS_BITS-1:0] pos_q, pos_d;
  logic [POS_BITS-1:0] pstart_q, pstart_d;
  logic [LEN_BITS-1:0] plen_q, plen_d;
  logic                ovf_q, ovf_d;
  prefix_t             prefix_q, prefix_d;

  logic       proc;
  logic [7:0] c;
  logic       is_dig, is_alp, restart, grow;
  kind_e      op;
  out_t       tok_a, tok_b;
  logic       a_vld, b_vld;

  assign proc       = in_vld_q && room_i;
  assign in_ready_o = !in_vld_q || proc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      pos_q    <= '0;
      pstart_q <= '0;
      plen_q   <= '0;
      ovf_q    <= 1'b0;
      prefix_q <= '0;
    end else if (proc) begin
      mode_q   <= mode_d;
      pos_q    <= pos_d;
      pstart_q <= pstart_d;
      plen_q   <= plen_d;
      ovf_q    <= ovf_d;
      prefix_q <= prefix_d;
    end
  end

  assign c      = in_q.char_code;
  assign is_dig = (c >= 8'h30) && (c <= 8'h39);
  assign is_alp = ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  assign op     = op_kind(c);

  always_comb begin
    mode_d   = mode_q;
    pos_d    = pos_q;
    pstart_d = pstart_q;
    plen_d   = plen_q;
    ovf_d    = ovf_q;
    prefix_d = prefix_q;
    restart  = 1'b0;
    grow     = 1'b0;
    a_vld    = 1'b0;
    b_vld    = 1'b0;

    // Pending token as it would be flushed now.
    tok_a.start_pos   = pstart_q;
    tok_a.last_of_run = 1'b0;
    case (mode_q)
      MODE_NUM: begin
        tok_a.token_kind    = KIND_NUMBER;
        tok_a.token_len     = plen_q;
        tok_a.len_saturated = ovf_q;
      end
      MODE_IDENT: begin
        tok_a.token_kind    = ident_kind(prefix_q, plen_q, ovf_q);
        tok_a.token_len     = plen_q;
        tok_a.len_saturated = ovf_q;
      end
      default: begin
        tok_a.token_kind    = KIND_EQUAL;
        tok_a.token_len     = LEN_BITS'(1);
        tok_a.len_saturated = 1'b0;
      end
    endcase

    tok_b.token_kind    = op;
    tok_b.start_pos     = pos_q;
    tok_b.token_len     = LEN_BITS'(1);
    tok_b.len_saturated = 1'b0;
    tok_b.last_of_run   = 1'b0;

    if (in_q.end_of_source) begin
      a_vld             = (mode_q != MODE_IDLE);
      b_vld             = 1'b1;
      tok_b.token_kind  = KIND_EOF;
      tok_b.token_len   = '0;
      mode_d            = MODE_IDLE;
      pos_d             = '0;
      pstart_d          = '0;
      plen_d            = '0;
      ovf_d             = 1'b0;
      prefix_d          = '0;
    end else begin
      case (mode_q)
        MODE_NUM: begin
          if (is_dig) begin
            grow = 1'b1;
          end else begin
            restart = 1'b1;
          end
        end
        MODE_IDENT: begin
          if (is_dig || is_alp) begin
            if (!ovf_q && plen_q < LEN_BITS'(KW_BYTES)) begin
              prefix_d[plen_q[2:0]] = c;
            end
            grow = 1'b1;
          end else begin
            restart = 1'b1;
          end
        end
        MODE_EQ: begin
          if (c == CH_EQ) begin
            b_vld            = 1'b1;
            tok_b.token_kind = KIND_EQEQ;
            tok_b.start_pos  = pstart_q;
            tok_b.token_len  = LEN_BITS'(2);
            mode_d           = MODE_IDLE;
            plen_d           = '0;
          end else begin
            restart = 1'b1;
          end
        end
        default: begin
          restart = 1'b1;
        end
      endcase

      if (grow) begin
        if (plen_q == LEN_MAX) begin
          ovf_d = 1'b1;
        end else begin
          plen_d = plen_q + LEN_BITS'(1);
        end
      end

      // Drop the pending token into slot a, then treat the byte from idle.
      if (restart) begin
        a_vld    = (mode_q != MODE_IDLE);
        mode_d   = MODE_IDLE;
        plen_d   = '0;
        ovf_d    = 1'b0;
        prefix_d = '0;
        if (op != KIND_EOF) begin
          b_vld = 1'b1;
        end else if (c == CH_EQ) begin
          mode_d   = MODE_EQ;
          pstart_d = pos_q;
          plen_d   = LEN_BITS'(1);
        end else if (is_dig) begin
          mode_d   = MODE_NUM;
          pstart_d = pos_q;
          plen_d   = LEN_BITS'(1);
        end else if (is_alp) begin
          mode_d      = MODE_IDENT;
          pstart_d    = pos_q;
          plen_d      = LEN_BITS'(1);
          prefix_d[0] = c;
        end
      end

      if (pos_q != POS_MAX) begin
        pos_d = pos_q + POS_BITS'(1);
      end
    end

    if (b_vld) begin
      tok_b.last_of_run = 1'b1;
    end else begin
      tok_a.last_of_run = 1'b1;
    end

    push_o.a_vld = a_vld && proc;
    push_o.a     = tok_a;
    push_o.b_vld = b_vld && proc;
    push_o.b     = tok_b;
  end

endmodule

`default_nettype wire

// ----- sv/kwl_out_fifo.sv -----
// ----------------------------------------------------------------------------
// kwl_out_fifo
// Four-entry result queue taking up to two tokens a cycle, giving one on ready.
// ----------------------------------------------------------------------------
`default_nettype none

module kwl_out_fifo import kwl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  kwl_push_t push_i,
  output logic      room_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_t      out_o
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  out_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             pop;
  logic [1:0]       npush;
  out_t             first;

  assign room_o      = cnt_q <= CNT_W'(DEPTH - 2);
  assign out_valid_o = cnt_q != '0;
  assign out_o       = mem_q[rd_q];
  assign pop         = out_valid_o && out_ready_i;
  assign npush       = {1'b0, push_i.a_vld} + {1'b0, push_i.b_vld};
  assign first       = push_i.a_vld ? push_i.a : push_i.b;

  always_ff @(posedge clk_i) begin
    if (npush != 2'd0) begin
      mem_q[wr_q] <= first;
    end
    if (npush == 2'd2) begin
      mem_q[wr_q + PTR_W'(1)] <= push_i.b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + PTR_W'(npush);
      if (pop) begin
        rd_q <= rd_q + PTR_W'(1);
      end
      cnt_q <= cnt_q + CNT_W'(npush) - CNT_W'(pop);
    end
  end

endmodule

`default_nettype wire

// ----- sv/keyword_token_lexer_top.sv -----
// ----------------------------------------------------------------------------
// keyword_token_lexer_top
// Byte-serial lexer that turns source bytes into kind/position/length tokens.
// ----------------------------------------------------------------------------
// Feed one source byte per item, then an item with end_of_source set to close
// the source. Each item is taken into an input register, scanned against the
// lexer state, and the zero, one or two tokens it causes are pushed into a
// four-entry result queue; the final token of each item carries last_of_run.
// The input side takes one item per cycle while the queue has room for two
// tokens; the output delivers one token per cycle while out_ready_i is high,
// so an item that closes a pending token and also emits its own takes two
// output slots. The first token an item causes passes from the input register
// into the queue once the queue has room, and is then shown at its output.
// The end item flushes any pending token, emits EOF and resets position
// and state, so the next byte starts a fresh source at offset zero.
// ----------------------------------------------------------------------------
`default_nettype none

module keyword_token_lexer_top import kwl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_o
);

  kwl_push_t push;
  logic      room;

  // Scanner: input register, mode/position state, token formation.
  kwl_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .room_i     (room),
    .push_o     (push)
  );

  // Result queue: hold tokens until the consumer takes them.
  kwl_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

// ----- sv/kwl_checker.sv -----
// ----------------------------------------------------------------------------
// kwl_checker
// Port-level checks of the keyword token lexer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "keyword_token_lexer_top_macros.svh"

module kwl_checker import kwl_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_o
);

  `KWL_ASSERT_ALWAYS(a_no_out_in_reset, !rst_ni |=> !out_valid_o, "token valid during reset")

  `KWL_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o), "stalled token changed")

  `KWL_ASSERT(a_eof_shape, out_valid_o && out_o.token_kind == KIND_EOF |-> out_o.last_of_run && out_o.token_len == '0 && !out_o.len_saturated, "malformed EOF token")

  `KWL_ASSERT(a_sat_kind, out_valid_o && out_o.len_saturated |-> out_o.token_kind == KIND_NUMBER || out_o.token_kind == KIND_IDENT, "saturation flag on fixed-length token")

endmodule

bind keyword_token_lexer_top kwl_checker u_kwl_checker (.*);

`default_nettype wire
